FILE: rtl/mfdl_pkg.sv
// ----------------------------------------------------------------------------
// mfdl_pkg
// Shared constants and codes of the modulated fractional delay line.
// ----------------------------------------------------------------------------
package mfdl_pkg;

   localparam int DEF_LINE_DEPTH    = 4096;
   localparam int DEF_SAMPLE_BITS   = 24;
   localparam int DEF_FRACTION_BITS = 16;

   // Configuration register indexes.
   localparam logic [1:0] CSR_BYPASS = 2'd0;
   localparam logic [1:0] CSR_MODE   = 2'd1;
   localparam logic [1:0] CSR_LENGTH = 2'd2;

   typedef enum logic [1:0] {
      MODE_FLOOR  = 2'd0,
      MODE_LINEAR = 2'd1,
      MODE_CUBIC  = 2'd2,
      MODE_MUTE   = 2'd3
   } interp_type;

endpackage

FILE: rtl/mfdl_ram.sv
// ----------------------------------------------------------------------------
// mfdl_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module mfdl_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

FILE: rtl/mfdl_queue.sv
// ----------------------------------------------------------------------------
// mfdl_queue
// Two-entry command queue between the front and the back part.
// ----------------------------------------------------------------------------
module mfdl_queue #(
   parameter type item_type = logic
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_data,
   output logic     full,
   input  logic     pop,
   output item_type pop_data,
   output logic     empty
);

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/mfdl_front.sv
// ----------------------------------------------------------------------------
// mfdl_front
// Accepts items, holds the configuration and the write index, and turns
// each item into a command with the four read addresses and the fraction.
// ----------------------------------------------------------------------------
module mfdl_front import mfdl_pkg::*; #(
   parameter int  LINE_DEPTH    = DEF_LINE_DEPTH,
   parameter int  SAMPLE_BITS   = DEF_SAMPLE_BITS,
   parameter int  FRACTION_BITS = DEF_FRACTION_BITS,
   parameter type cmd_type      = logic
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          csr_write_enable,
   input  logic [1:0]                                    csr_index,
   input  logic [$clog2(LINE_DEPTH):0]                   csr_wdata,
   input  logic                                          req_valid,
   output logic                                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0]                 req_left_in,
   input  logic signed [SAMPLE_BITS-1:0]                 req_right_in,
   input  logic [$clog2(LINE_DEPTH)+FRACTION_BITS-1:0]   req_delay_offset,
   input  logic                                          clearing,
   output logic                                          q_push,
   output cmd_type                                       q_data,
   input  logic                                          q_full
);

   localparam int AB = $clog2(LINE_DEPTH);
   localparam int LW = AB + 1;
   localparam int F  = FRACTION_BITS;
   localparam logic [LW-1:0] LEN_MAX = LW'(LINE_DEPTH);
   localparam logic [LW-1:0] LEN_MIN = LW'(4);

   logic             bypass_ff;
   interp_type       mode_ff;
   logic [LW-1:0]    length_ff;
   logic [AB-1:0]    wi_ff, wi_in;

   logic                          hold_ff, hold_in;
   logic                          h_bypass_ff;
   interp_type                    h_mode_ff;
   logic signed [SAMPLE_BITS-1:0] h_left_ff, h_right_ff;
   logic [LW-1:0]                 h_len_ff;
   logic [AB-1:0]                 h_wi_ff;
   logic [AB+F-1:0]               h_delay_ff;

   logic [LW-1:0]   len_eff, wi_eff, wi_inc;
   logic [LW+F-1:0] max_delay, delay_clamp;
   logic            accept;

   logic [LW-1:0]   base, ip_raw, ip, im, i1t, i1, i2t, i2;
   logic [LW+F-1:0] pos;

   assign req_ready = !hold_ff && !clearing;
   assign accept    = req_valid && req_ready;
   assign q_push    = hold_ff && !q_full;

   always_comb begin
      if (length_ff < LEN_MIN) begin
         len_eff = LEN_MIN;
      end else if (length_ff > LEN_MAX) begin
         len_eff = LEN_MAX;
      end else begin
         len_eff = length_ff;
      end
      wi_eff      = ({1'b0, wi_ff} >= len_eff) ? '0 : {1'b0, wi_ff};
      wi_inc      = wi_eff + LW'(1);
      max_delay   = {len_eff - LW'(1), {F{1'b0}}};
      delay_clamp = ({1'b0, req_delay_offset} > max_delay) ? max_delay
                                                            : {1'b0, req_delay_offset};
      wi_in = wi_ff;
      if (accept && !bypass_ff) begin
         wi_in = (wi_inc >= len_eff) ? '0 : wi_inc[AB-1:0];
      end
      hold_in = hold_ff;
      if (accept) begin
         hold_in = 1'b1;
      end else if (q_push) begin
         hold_in = 1'b0;
      end
   end

   // Read position: the stored delay never exceeds (L - 1) samples, so the
   // position stays at or above the write index and one wrap is enough.
   always_comb begin
      base   = {1'b0, h_wi_ff} + h_len_ff - LW'(1);
      pos    = {base, {F{1'b0}}} - {1'b0, h_delay_ff};
      ip_raw = pos[LW+F-1:F];
      ip     = (ip_raw >= h_len_ff) ? ip_raw - h_len_ff : ip_raw;
      im     = (ip == '0) ? h_len_ff - LW'(1) : ip - LW'(1);
      i1t    = ip + LW'(1);
      i1     = (i1t >= h_len_ff) ? i1t - h_len_ff : i1t;
      i2t    = ip + LW'(2);
      i2     = (i2t >= h_len_ff) ? i2t - h_len_ff : i2t;

      q_data         = '0;
      q_data.bypass  = h_bypass_ff;
      q_data.mode    = h_mode_ff;
      q_data.left    = h_left_ff;
      q_data.right   = h_right_ff;
      q_data.idx_m   = im[AB-1:0];
      q_data.idx_0   = ip[AB-1:0];
      q_data.idx_1   = i1[AB-1:0];
      q_data.idx_2   = i2[AB-1:0];
      q_data.wr_addr = h_wi_ff;
      q_data.frac    = pos[F-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bypass_ff <= 1'b0;
         mode_ff   <= MODE_LINEAR;
         length_ff <= LEN_MAX;
         wi_ff     <= '0;
         hold_ff   <= 1'b0;
      end else begin
         wi_ff   <= wi_in;
         hold_ff <= hold_in;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_BYPASS: bypass_ff <= csr_wdata[0];
               CSR_MODE:   mode_ff   <= interp_type'(csr_wdata[1:0]);
               CSR_LENGTH: length_ff <= csr_wdata;
               default:    ;
            endcase
         end
      end
      if (accept) begin
         h_bypass_ff <= bypass_ff;
         h_mode_ff   <= mode_ff;
         h_left_ff   <= req_left_in;
         h_right_ff  <= req_right_in;
         h_len_ff    <= len_eff;
         h_wi_ff     <= wi_eff[AB-1:0];
         h_delay_ff  <= delay_clamp[AB+F-1:0];
      end
   end

endmodule

FILE: rtl/mfdl_back.sv
// ----------------------------------------------------------------------------
// mfdl_back
// Clears the delay lines after reset, then carries out commands: four line
// reads, interpolation over six arithmetic steps, write of the new frame.
// ----------------------------------------------------------------------------
module mfdl_back import mfdl_pkg::*; #(
   parameter int  LINE_DEPTH    = DEF_LINE_DEPTH,
   parameter int  SAMPLE_BITS   = DEF_SAMPLE_BITS,
   parameter int  FRACTION_BITS = DEF_FRACTION_BITS,
   parameter type cmd_type      = logic
) (
   input  logic                          clock,
   input  logic                          reset,
   output logic                          clearing,
   input  logic                          q_empty,
   input  cmd_type                       q_data,
   output logic                          q_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_left_out,
   output logic signed [SAMPLE_BITS-1:0] rsp_right_out
);

   localparam int AB = $clog2(LINE_DEPTH);
   localparam int S  = SAMPLE_BITS;
   localparam int F  = FRACTION_BITS;
   localparam int AW = S + F + 8;
   localparam int MW = S + 6;
   localparam logic signed [AW-1:0] ONE    = AW'(1);
   localparam logic signed [AW-1:0] SAT_HI = (ONE <<< (S - 1)) - ONE;
   localparam logic signed [AW-1:0] SAT_LO = -SAT_HI - ONE;

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_READ  = 5'b00100,
      ST_CALC  = 5'b01000,
      ST_WRITE = 5'b10000
   } state_type;

   state_type      state_ff, state_in;
   logic [AB-1:0]  clr_ff, clr_in;
   logic [2:0]     step_ff, step_in;
   cmd_type        cur_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   logic signed [S-1:0] out_l_ff, out_r_ff;

   logic signed [S-1:0]  smp_ff  [2][4];
   logic signed [AW-1:0] acc_ff  [2];
   logic signed [AW-1:0] prod_ff [2];
   logic signed [AW-1:0] acc_in  [2];
   logic signed [AW-1:0] prod_in [2];
   logic signed [S-1:0]  res     [2];

   logic          ram_we;
   logic [AB-1:0] ram_waddr, ram_raddr;
   logic [S-1:0]  ram_wdata [2];
   logic [S-1:0]  ram_rdata [2];
   logic          out_free, load_out, load_bypass;

   function automatic logic signed [AW-1:0] rnd(input logic signed [AW-1:0] v,
                                                input int s);
      return (v + (ONE <<< (s - 1))) >>> s;
   endfunction

   function automatic logic signed [S-1:0] sat(input logic signed [AW-1:0] v);
      logic signed [S-1:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI[S-1:0];
      end else if (v < SAT_LO) begin
         r = SAT_LO[S-1:0];
      end else begin
         r = v[S-1:0];
      end
      return r;
   endfunction

   assign clearing      = (state_ff == ST_CLEAR);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_left_out  = out_l_ff;
   assign rsp_right_out = out_r_ff;
   assign out_free      = !rsp_valid_ff || rsp_ready;

   for (genvar ch = 0; ch < 2; ch++) begin : g_lane
      mfdl_ram #(
         .WIDTH(S),
         .DEPTH(LINE_DEPTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (ram_we),
         .wr_addr (ram_waddr),
         .wr_data (ram_wdata[ch]),
         .rd_addr (ram_raddr),
         .rd_data (ram_rdata[ch])
      );
   end

   // Interpolation datapath, one lane per channel. Linear finishes at step
   // one; cubic runs the Horner steps through step five.
   always_comb begin
      for (int ch = 0; ch < 2; ch++) begin
         logic signed [AW-1:0]  p, a, b, q, c0, c1, c2, op;
         logic signed [MW+F:0]  pr;
         p  = AW'(smp_ff[ch][0]);
         a  = AW'(smp_ff[ch][1]);
         b  = AW'(smp_ff[ch][2]);
         q  = AW'(smp_ff[ch][3]);
         c0 = -p + 3 * a - 3 * b + q;
         c1 = 2 * p - 5 * a + 4 * b - q;
         c2 = b - p;
         if (step_ff == 3'd0) begin
            op = (cur_ff.mode == MODE_LINEAR) ? b - a : c0;
         end else begin
            op = acc_ff[ch];
         end
         pr = $signed(op[MW-1:0]) * $signed({1'b0, cur_ff.frac});
         prod_in[ch] = prod_ff[ch];
         acc_in[ch]  = acc_ff[ch];
         if (state_ff == ST_CALC) begin
            case (step_ff)
               3'd0, 3'd2, 3'd4: prod_in[ch] = AW'(pr);
               3'd1: begin
                  if (cur_ff.mode == MODE_LINEAR) begin
                     acc_in[ch] = rnd((a <<< F) + prod_ff[ch], F);
                  end else begin
                     acc_in[ch] = rnd(prod_ff[ch], F) + c1;
                  end
               end
               3'd3: begin
                  if (cur_ff.mode == MODE_CUBIC) begin
                     acc_in[ch] = rnd(prod_ff[ch], F) + c2;
                  end
               end
               3'd5: begin
                  if (cur_ff.mode == MODE_CUBIC) begin
                     acc_in[ch] = rnd(prod_ff[ch] + (a <<< (F + 1)), F + 1);
                  end
               end
               default: ;
            endcase
         end
         case (cur_ff.mode)
            MODE_FLOOR:  res[ch] = smp_ff[ch][1];
            MODE_LINEAR: res[ch] = sat(acc_ff[ch]);
            MODE_CUBIC:  res[ch] = sat(acc_ff[ch]);
            default:     res[ch] = '0;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      step_in      = step_ff;
      q_pop        = 1'b0;
      load_out     = 1'b0;
      load_bypass  = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = cur_ff.wr_addr;
      ram_wdata[0] = cur_ff.left;
      ram_wdata[1] = cur_ff.right;
      case (step_ff[1:0])
         2'd0:    ram_raddr = cur_ff.idx_m;
         2'd1:    ram_raddr = cur_ff.idx_0;
         2'd2:    ram_raddr = cur_ff.idx_1;
         default: ram_raddr = cur_ff.idx_2;
      endcase
      case (state_ff)
         ST_CLEAR: begin
            ram_we       = 1'b1;
            ram_waddr    = clr_ff;
            ram_wdata[0] = '0;
            ram_wdata[1] = '0;
            clr_in       = clr_ff + AB'(1);
            if (clr_ff == AB'(LINE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!q_empty) begin
               if (q_data.bypass) begin
                  if (out_free) begin
                     q_pop       = 1'b1;
                     load_bypass = 1'b1;
                  end
               end else begin
                  q_pop    = 1'b1;
                  step_in  = 3'd0;
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd4) begin
               step_in  = 3'd0;
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd5) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            if (out_free) begin
               ram_we   = 1'b1;
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = (load_out || load_bypass) ? 1'b1
                   : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (q_pop) begin
         cur_ff <= q_data;
      end
      if (load_bypass) begin
         out_l_ff <= q_data.left;
         out_r_ff <= q_data.right;
      end else if (load_out) begin
         out_l_ff <= res[0];
         out_r_ff <= res[1];
      end
      // Read data arrives in the cycle after its address.
      if (state_ff == ST_READ && step_ff != 3'd0) begin
         for (int ch = 0; ch < 2; ch++) begin
            smp_ff[ch][step_ff[1:0] - 2'd1] <= ram_rdata[ch];
         end
      end
      for (int ch = 0; ch < 2; ch++) begin
         acc_ff[ch]  <= acc_in[ch];
         prod_ff[ch] <= prod_in[ch];
      end
   end

endmodule

FILE: rtl/modulated_fractional_delay_line.sv
// ----------------------------------------------------------------------------
// modulated_fractional_delay_line
// Stereo modulated delay line with floor, linear or cubic interpolation.
// ----------------------------------------------------------------------------
// The back sequencer carries out one command at a time: four reads on the
// single read port of each line memory, six interpolation steps and the
// write; bypass items go straight to the output register. Meanwhile the
// front accepts new items until its hold register and the queue are full.
// Reset: synchronous; afterwards a clearing pass zeroes both lines, during
// which no item is accepted (configuration writes are).
module modulated_fractional_delay_line import mfdl_pkg::*; #(
   parameter int LINE_DEPTH    = DEF_LINE_DEPTH,
   parameter int SAMPLE_BITS   = DEF_SAMPLE_BITS,
   parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        csr_write_enable,
   input  logic [1:0]                                  csr_index,
   input  logic [$clog2(LINE_DEPTH):0]                 csr_wdata,
   input  logic                                        req_valid,
   output logic                                        req_ready,
   input  logic signed [SAMPLE_BITS-1:0]               req_left_in,
   input  logic signed [SAMPLE_BITS-1:0]               req_right_in,
   input  logic [$clog2(LINE_DEPTH)+FRACTION_BITS-1:0] req_delay_offset,
   output logic                                        rsp_valid,
   input  logic                                        rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]               rsp_left_out,
   output logic signed [SAMPLE_BITS-1:0]               rsp_right_out
);

   localparam int AB = $clog2(LINE_DEPTH);

   typedef struct packed {
      logic                          bypass;
      interp_type                    mode;
      logic signed [SAMPLE_BITS-1:0] left;
      logic signed [SAMPLE_BITS-1:0] right;
      logic [AB-1:0]                 idx_m;
      logic [AB-1:0]                 idx_0;
      logic [AB-1:0]                 idx_1;
      logic [AB-1:0]                 idx_2;
      logic [AB-1:0]                 wr_addr;
      logic [FRACTION_BITS-1:0]      frac;
   } cmd_type;

   cmd_type push_data, pop_data;
   logic    q_push, q_full, q_pop, q_empty, clearing;

   mfdl_front #(
      .LINE_DEPTH    (LINE_DEPTH),
      .SAMPLE_BITS   (SAMPLE_BITS),
      .FRACTION_BITS (FRACTION_BITS),
      .cmd_type      (cmd_type)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_left_in      (req_left_in),
      .req_right_in     (req_right_in),
      .req_delay_offset (req_delay_offset),
      .clearing         (clearing),
      .q_push           (q_push),
      .q_data           (push_data),
      .q_full           (q_full)
   );

   mfdl_queue #(
      .item_type (cmd_type)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (pop_data),
      .empty     (q_empty)
   );

   mfdl_back #(
      .LINE_DEPTH    (LINE_DEPTH),
      .SAMPLE_BITS   (SAMPLE_BITS),
      .FRACTION_BITS (FRACTION_BITS),
      .cmd_type      (cmd_type)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .clearing      (clearing),
      .q_empty       (q_empty),
      .q_data        (pop_data),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_left_out  (rsp_left_out),
      .rsp_right_out (rsp_right_out)
   );

   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !req_ready)
      else $error("item accepted during line clearing");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("command queue overflow");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("command queue underflow");

endmodule

FILE: sim/mfdl_checker.sv
// ----------------------------------------------------------------------------
// mfdl_checker
// Watches the register port and both item channels of the delay line, keeps
// its own copy of the lines, the write index and the registers, predicts the
// output frame of every accepted item and compares it with the result.
// ----------------------------------------------------------------------------
module mfdl_checker import mfdl_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [1:0]          csr_index,
   input  logic [12:0]         csr_wdata,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic signed [23:0]  req_left_in,
   input  logic signed [23:0]  req_right_in,
   input  logic [27:0]         req_delay_offset,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic signed [23:0]  rsp_left_out,
   input  logic signed [23:0]  rsp_right_out,
   output int                  frames_pending,
   output int                  fail_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = DEF_LINE_DEPTH;
   localparam int FB    = DEF_FRACTION_BITS;

   typedef struct {
      logic signed [23:0] left;
      logic signed [23:0] right;
   } frame_type;

   logic signed [23:0] left_store [DEPTH];
   logic signed [23:0] right_store [DEPTH];
   int unsigned        wr_ptr;
   logic               bypass_on;
   interp_type         mode;
   logic [12:0]        length_reg;
   frame_type          frames_due [$];

   function automatic longint round_sh(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint clip24(longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return v;
   endfunction

   function automatic longint interpolate(longint p, longint a, longint b, longint q,
                                          longint f);
      longint t;
      case (mode)
         MODE_FLOOR: return a;
         MODE_LINEAR: begin
            t = a * (longint'(1) << FB) + f * (b - a);
            return clip24(round_sh(t, FB));
         end
         MODE_CUBIC: begin
            t = -p + 3 * a - 3 * b + q;
            t = round_sh(t * f, FB) + (2 * p - 5 * a + 4 * b - q);
            t = round_sh(t * f, FB) + (b - p);
            t = t * f + a * (longint'(1) << (FB + 1));
            return clip24(round_sh(t, FB + 1));
         end
         default: return 0;
      endcase
   endfunction

   function automatic frame_type delay_frame(logic signed [23:0] l_in,
                                             logic signed [23:0] r_in,
                                             logic [27:0] delay);
      frame_type   res;
      int unsigned len, ip, im, i1, i2;
      longint      d, pos, f;
      if (bypass_on) begin
         res.left = l_in;
         res.right = r_in;
         return res;
      end
      len = length_reg;
      if (len < 4) len = 4;
      if (len > DEPTH) len = DEPTH;
      if (wr_ptr >= len) wr_ptr = 0;
      d = delay;
      if (d > (longint'(len - 1) << FB)) d = longint'(len - 1) << FB;
      pos = (longint'(wr_ptr + len - 1) << FB) - d;
      ip = int'(pos >> FB);
      if (ip >= len) ip -= len;
      if (ip >= len) ip = 0;
      f = pos & ((longint'(1) << FB) - 1);
      im = (ip + len - 1) % len;
      i1 = (ip + 1) % len;
      i2 = (ip + 2) % len;
      res.left = 24'(interpolate(left_store[im], left_store[ip], left_store[i1],
                                 left_store[i2], f));
      res.right = 24'(interpolate(right_store[im], right_store[ip], right_store[i1],
                                  right_store[i2], f));
      left_store[wr_ptr] = l_in;
      right_store[wr_ptr] = r_in;
      wr_ptr++;
      if (wr_ptr >= len) wr_ptr = 0;
      return res;
   endfunction

   initial fail_count = 0;

   always @(posedge clock) begin
      frame_type exp_frame;
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            left_store[i] = '0;
            right_store[i] = '0;
         end
         wr_ptr = 0;
         bypass_on = 1'b0;
         mode = MODE_LINEAR;
         length_reg = 13'd4096;
         frames_due.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_BYPASS: bypass_on = csr_wdata[0];
               CSR_MODE:   mode = interp_type'(csr_wdata[1:0]);
               CSR_LENGTH: length_reg = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            frames_due.push_back(delay_frame(req_left_in, req_right_in, req_delay_offset));
         if (rsp_valid && rsp_ready) begin
            if (frames_due.size() == 0) begin
               $display("%0t: unexpected item, left %0d right %0d", $time,
                        rsp_left_out, rsp_right_out);
               fail_count++;
            end else begin
               exp_frame = frames_due.pop_front();
               if (rsp_left_out !== exp_frame.left) begin
                  $display("%0t: left_out expected %0d actual %0d", $time,
                           exp_frame.left, rsp_left_out);
                  fail_count++;
               end
               if (rsp_right_out !== exp_frame.right) begin
                  $display("%0t: right_out expected %0d actual %0d", $time,
                           exp_frame.right, rsp_right_out);
                  fail_count++;
               end
            end
         end
      end
      frames_pending = frames_due.size();
   end

endmodule

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives the delay line through a series of register settings with directed
// and random stereo frames and random stalls on both channels; the checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top import mfdl_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 700000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_write_enable = 1'b0;
   logic [1:0]         csr_index = CSR_BYPASS;
   logic [12:0]        csr_wdata = '0;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [23:0] req_left_in = '0;
   logic signed [23:0] req_right_in = '0;
   logic [27:0]        req_delay_offset = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [23:0] rsp_left_out;
   logic signed [23:0] rsp_right_out;
   int                 frames_pending;
   int                 fail_count;
   int                 cycle_count = 0;
   int                 stall_left = 0;
   logic               steady_drain = 1'b0;
   int unsigned        cur_length = 4096;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   modulated_fractional_delay_line dut (.*);

   mfdl_checker checker_i (.*);

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // The receiver stalls at random, except during stretches with steady drain.
   always @(posedge clock) begin
      if (reset || steady_drain) begin
         rsp_ready <= !reset;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         stall_left <= gap_length();
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   task automatic send_frame(logic signed [23:0] l, logic signed [23:0] r, logic [27:0] d);
      int n;
      req_valid <= 1'b1;
      req_left_in <= l;
      req_right_in <= r;
      req_delay_offset <= d;
      do @(posedge clock); while (!req_ready);
      n = gap_length();
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // The pending count is updated at the same edge that wakes this task, so it
   // waits for the next edge first so that the last accepted item is counted.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (frames_pending != 0) @(posedge clock);
      repeat (24) @(posedge clock);
   endtask

   // Registers only change while the block is idle; the caller has drained.
   task automatic set_regs(logic bypass, interp_type m, logic [12:0] len);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_BYPASS;
      csr_wdata <= 13'(bypass);
      @(posedge clock);
      csr_index <= CSR_MODE;
      csr_wdata <= 13'(m);
      @(posedge clock);
      csr_index <= CSR_LENGTH;
      csr_wdata <= len;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cur_length = (len < 4) ? 4 : (len > 4096) ? 4096 : len;
   endtask

   function automatic logic signed [23:0] rand_sample();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 24'sh7FFFFF;
      if (r == 1) return -24'sh800000;
      return 24'($urandom);
   endfunction

   function automatic logic [27:0] rand_delay();
      int r;
      r = $urandom_range(0, 9);
      if (r < 3) return 28'($urandom);
      if (r == 3) return 28'((cur_length - 1) << 16);
      return 28'($urandom_range(0, ((cur_length - 1) << 16)));
   endfunction

   task automatic random_frames(int count);
      repeat (count) send_frame(rand_sample(), rand_sample(), rand_delay());
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed frames at reset settings: extremes of samples and delays.
      send_frame(24'sh7FFFFF, -24'sh800000, 28'd0);
      send_frame(-24'sh800000, 24'sh7FFFFF, 28'd0);
      send_frame(24'sh000000, -24'sh000001, 28'h0010000);
      send_frame(-24'sh000001, 24'sh000001, 28'h0018000);
      send_frame(24'sh7FFFFF, 24'sh7FFFFF, 28'h000FFFF);
      send_frame(-24'sh800000, -24'sh800000, 28'hFFFFFFF);
      send_frame(24'sh123456, -24'sh654321, 28'h0FFF0000);
      send_frame(24'sh555555, -24'sh2AAAAA, 28'h0020001);
      random_frames(92);
      drain();

      // Write index now lies beyond the new length.
      set_regs(1'b0, MODE_FLOOR, 13'd16);
      send_frame(24'sh7FFFFF, -24'sh800000, 28'hFFFFFFF);
      send_frame(-24'sh800000, 24'sh7FFFFF, 28'd0);
      random_frames(98);
      drain();

      // Shortest line with cubic interpolation, full swings.
      set_regs(1'b0, MODE_CUBIC, 13'd4);
      send_frame(24'sh7FFFFF, -24'sh800000, 28'h0008000);
      send_frame(-24'sh800000, 24'sh7FFFFF, 28'h0018000);
      send_frame(24'sh7FFFFF, -24'sh800000, 28'h0027FFF);
      send_frame(-24'sh800000, 24'sh7FFFFF, 28'h000C000);
      random_frames(96);
      drain();

      set_regs(1'b0, MODE_MUTE, 13'd8);
      random_frames(40);
      drain();

      set_regs(1'b1, MODE_LINEAR, 13'd32);
      send_frame(24'sh7FFFFF, -24'sh800000, 28'hFFFFFFF);
      random_frames(49);
      drain();

      // Out-of-range lengths act as the nearest limit.
      set_regs(1'b0, MODE_CUBIC, 13'd8191);
      random_frames(100);
      drain();

      set_regs(1'b0, MODE_LINEAR, 13'd0);
      random_frames(80);
      drain();

      steady_drain = 1'b1;
      set_regs(1'b0, MODE_CUBIC, 13'd100);
      random_frames(100);
      drain();
      steady_drain = 1'b0;

      set_regs(1'b0, MODE_LINEAR, 13'd37);
      random_frames(60);
      drain();

      set_regs(1'b0, MODE_FLOOR, 13'd4096);
      random_frames(60);
      drain();

      set_regs(1'b0, MODE_CUBIC, 13'd13);
      random_frames(100);
      drain();

      if (fail_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
